// File: src/fcas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcas_pkg
// shared constants for the four channel actuator sequencer
// ----------------------------------------------------------------------------
package fcas_pkg;

  localparam int CHANNELS = 4;
  localparam int MASK_W   = 4;
  localparam int PHASE_W  = 4;
  localparam int COUNT_W  = 17;
  localparam int TICKS_W  = 16;
  localparam int CHAN_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [PHASE_W-1:0] PH_IDLE        = 4'd0;
  localparam logic [PHASE_W-1:0] PH_START_OPEN  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_OPENING     = 4'd2;
  localparam logic [PHASE_W-1:0] PH_OPENED      = 4'd3;
  localparam logic [PHASE_W-1:0] PH_HOLDING     = 4'd4;
  localparam logic [PHASE_W-1:0] PH_HELD        = 4'd5;
  localparam logic [PHASE_W-1:0] PH_START_CLOSE = 4'd6;
  localparam logic [PHASE_W-1:0] PH_CLOSING     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_CLOSED      = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TICKS = 8'd3;

  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_TRIGGER = 1'b1;

  localparam logic [TICKS_W-1:0] OPEN_TICKS_RST  = 16'd50;
  localparam logic [TICKS_W-1:0] HOLD_TICKS_RST  = 16'd5000;
  localparam logic [TICKS_W-1:0] CLOSE_TICKS_RST = 16'd50;

endpackage

// File: src/four_channel_actuator_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_actuator_sequencer_core
// four actuator channels stepping open / hold / close on tick and trigger words
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one word per event: tuser = func (0 tick, 1 trigger),
//   tdata = trigger channel. a tick steps each busy channel on (timed phases
//   count to their threshold first), a trigger starts an idle channel or
//   restarts a holding one while enable is set, and toggles the led bit.
//   every accepted word gives exactly one m_axis word with the drive masks,
//   busy mask and led level as they stand after that event.
//   cfg_* writes the enable and tick threshold registers; cfg_ready is
//   always high.
// timing:
//   one word per cycle while the receiver keeps up; the result is registered
//   into the output register on acceptance. the per-channel phase update is a single compare
//   and increment between the state registers and the output register.
//   if the receiver stalls, the output register holds its word and s_axis
//   accepts again as soon as that word is taken (same cycle allowed).
// reset:
//   rst clears all channels to idle, counts and led to zero, enable to 0 and
//   the thresholds to 50 / 5000 / 50; the output register is emptied.
// ----------------------------------------------------------------------------
module four_channel_actuator_sequencer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [fcas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [1:0] channel
  input  logic                               s_axis_tuser,  // [0] func
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [3:0] forward_mask, [7:4] reverse_mask, [11:8] busy_mask, [12] led
  output logic [fcas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fcas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcas_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fcas_pkg::*;

  logic                 enable;
  logic [TICKS_W-1:0]   open_ticks;
  logic [TICKS_W-1:0]   hold_ticks;
  logic [TICKS_W-1:0]   close_ticks;

  logic [PHASE_W-1:0]   phase      [CHANNELS];
  logic [COUNT_W-1:0]   count      [CHANNELS];
  logic [PHASE_W-1:0]   phase_next [CHANNELS];
  logic [COUNT_W-1:0]   count_next [CHANNELS];
  logic                 led_level;
  logic                 led_level_next;

  logic [MASK_W-1:0]    fwd_mask;
  logic [MASK_W-1:0]    rev_mask;
  logic [MASK_W-1:0]    busy_mask;

  logic                 in_fire;
  logic [CHAN_W-1:0]    in_chan;
  logic                 in_func;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_chan       = s_axis_tdata[CHAN_W-1:0];
  assign in_func       = s_axis_tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      open_ticks  <= OPEN_TICKS_RST;
      hold_ticks  <= HOLD_TICKS_RST;
      close_ticks <= CLOSE_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:      enable      <= cfg_data[0];
        REG_OPEN_TICKS:  open_ticks  <= cfg_data[TICKS_W-1:0];
        REG_HOLD_TICKS:  hold_ticks  <= cfg_data[TICKS_W-1:0];
        REG_CLOSE_TICKS: close_ticks <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // next channel state for the word at the input
  always_comb begin
    led_level_next = led_level;
    for (int c = 0; c < CHANNELS; c++) begin
      phase_next[c] = phase[c];
      count_next[c] = count[c];
      if (in_func == FUNC_TICK) begin
        case (phase[c])
          PH_IDLE: ;
          PH_START_OPEN: begin
            phase_next[c] = PH_OPENING;
            count_next[c] = '0;
          end
          PH_OPENING: begin
            if (count[c] >= {1'b0, open_ticks}) phase_next[c] = PH_OPENED;
            count_next[c] = count[c] + 1'b1;
          end
          PH_OPENED: begin
            phase_next[c] = PH_HOLDING;
            count_next[c] = '0;
          end
          PH_HOLDING: begin
            if (count[c] >= {1'b0, hold_ticks}) phase_next[c] = PH_HELD;
            count_next[c] = count[c] + 1'b1;
          end
          PH_HELD: phase_next[c] = PH_START_CLOSE;
          PH_START_CLOSE: begin
            phase_next[c] = PH_CLOSING;
            count_next[c] = '0;
          end
          PH_CLOSING: begin
            // closing runs one tick past the threshold
            if (count[c] > {1'b0, close_ticks}) phase_next[c] = PH_CLOSED;
            count_next[c] = count[c] + 1'b1;
          end
          default: phase_next[c] = PH_IDLE;
        endcase
      end else if (int'(in_chan) == c && enable) begin
        if (phase[c] == PH_IDLE) begin
          phase_next[c] = PH_START_OPEN;
          count_next[c] = '0;
        end else if (phase[c] == PH_HOLDING) begin
          count_next[c] = '0;
        end
      end
    end
    // triggers on channels that do not exist are dropped, led included
    if (in_func == FUNC_TRIGGER && int'(in_chan) < CHANNELS) begin
      led_level_next = !led_level;
    end
  end

  always_comb begin
    fwd_mask  = '0;
    rev_mask  = '0;
    busy_mask = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < MASK_W) begin
        fwd_mask[c]  = phase_next[c] == PH_OPENING || phase_next[c] == PH_OPENED;
        rev_mask[c]  = phase_next[c] == PH_CLOSING || phase_next[c] == PH_CLOSED;
        busy_mask[c] = phase_next[c] != PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase[c] <= PH_IDLE;
        count[c] <= '0;
      end
      led_level <= 1'b0;
    end else if (in_fire) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase[c] <= phase_next[c];
        count[c] <= count_next[c];
      end
      led_level <= led_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {3'b000, led_level_next, busy_mask, rev_mask, fwd_mask};
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the four channel actuator sequencer core
// ----------------------------------------------------------------------------
// tick and trigger words go in through the stream input. Each accepted word
// goes through a behavioral copy of the four channel state machines, which
// gives the status word expected next. The output stream is compared field
// by field against those expectations, in order. Threshold and enable
// registers change only while nothing is in flight. The sender idles in
// random bursts and the receiver stalls on its own pattern, including one
// long hold-off that backs the core up. A watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb;
  import fcas_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int LONG_STALL      = 60;
  localparam int STALL_AFTER     = 400;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_WORDS     = 100;

  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] chan;
  } event_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] fwd_mask;
    logic [MASK_W-1:0] rev_mask;
    logic [MASK_W-1:0] busy_mask;
    logic              led;
  } status_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [1:0] channel
  logic                   s_axis_tuser = 1'b0;  // [0] func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [3:0] forward_mask, [7:4] reverse_mask, [11:8] busy_mask, [12] led
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // behavioral copy of the core state and registers
  logic [PHASE_W-1:0] chan_phase [CHANNELS];
  logic [COUNT_W-1:0] chan_count [CHANNELS];
  logic               led_state = 1'b0;
  logic               en_reg = 1'b0;
  logic [TICKS_W-1:0] open_lim  = OPEN_TICKS_RST;
  logic [TICKS_W-1:0] hold_lim  = HOLD_TICKS_RST;
  logic [TICKS_W-1:0] close_lim = CLOSE_TICKS_RST;

  event_word_t  pending_events [$];
  status_word_t expected_status [$];
  int           errors = 0;
  int           words_accepted = 0;

  // sender pacing
  int burst_left = 0;
  int gap_left   = 0;
  // receiver pacing
  int  stall_left = 0;
  bit  long_stall_done = 1'b0;
  int  sink_mode = 0;
  int  sink_mode_left = 0;

  four_channel_actuator_sequencer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      chan_phase[c] = PH_IDLE;
      chan_count[c] = '0;
    end
  end

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR t=%0t %s", $realtime, msg);
    errors++;
  endtask

  // apply one event to the channel copies and return the status after it
  function automatic status_word_t advance_sequencer(input event_word_t w);
    status_word_t       s;
    logic [COUNT_W-1:0] n;
    s = '0;
    if (w.func == FUNC_TICK) begin
      for (int c = 0; c < CHANNELS; c++) begin
        n = chan_count[c];
        case (chan_phase[c])
          PH_IDLE: ;
          PH_START_OPEN: begin
            chan_phase[c] = PH_OPENING;
            chan_count[c] = '0;
          end
          PH_OPENING: begin
            if (n >= open_lim) chan_phase[c] = PH_OPENED;
            chan_count[c] = n + 1'b1;
          end
          PH_OPENED: begin
            chan_phase[c] = PH_HOLDING;
            chan_count[c] = '0;
          end
          PH_HOLDING: begin
            if (n >= hold_lim) chan_phase[c] = PH_HELD;
            chan_count[c] = n + 1'b1;
          end
          PH_HELD: chan_phase[c] = PH_START_CLOSE;
          PH_START_CLOSE: begin
            chan_phase[c] = PH_CLOSING;
            chan_count[c] = '0;
          end
          PH_CLOSING: begin
            // strict compare: reverse drive runs one tick past the threshold
            if (n > close_lim) chan_phase[c] = PH_CLOSED;
            chan_count[c] = n + 1'b1;
          end
          default: chan_phase[c] = PH_IDLE;
        endcase
      end
    end else if (int'(w.chan) < CHANNELS) begin
      if (en_reg) begin
        if (chan_phase[w.chan] == PH_IDLE) begin
          chan_phase[w.chan] = PH_START_OPEN;
          chan_count[w.chan] = '0;
        end else if (chan_phase[w.chan] == PH_HOLDING) begin
          chan_count[w.chan] = '0;
        end
      end
      led_state = ~led_state;
    end
    for (int c = 0; c < CHANNELS && c < MASK_W; c++) begin
      s.fwd_mask[c]  = (chan_phase[c] == PH_OPENING) || (chan_phase[c] == PH_OPENED);
      s.rev_mask[c]  = (chan_phase[c] == PH_CLOSING) || (chan_phase[c] == PH_CLOSED);
      s.busy_mask[c] = (chan_phase[c] != PH_IDLE);
    end
    s.led = led_state;
    return s;
  endfunction

  function automatic void queue_event(input logic f, input logic [CHAN_W-1:0] ch);
    event_word_t w;
    w.func = f;
    w.chan = ch;
    pending_events.push_back(w);
  endfunction

  function automatic logic [TICKS_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return TICKS_W'($urandom_range(0, 65535));
      default: return TICKS_W'($urandom_range(0, 5));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE:      en_reg    = val[0];
      REG_OPEN_TICKS:  open_lim  = val[TICKS_W-1:0];
      REG_HOLD_TICKS:  hold_lim  = val[TICKS_W-1:0];
      REG_CLOSE_TICKS: close_lim = val[TICKS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_status.size() != 0) @(posedge clk);
  endtask

  // driver: bursts of words from the pending queue, valid held until taken
  always @(posedge clk) begin : event_driver
    logic        nv;
    event_word_t nw;
    nv = 1'b0;
    nw = '0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_status.push_back(advance_sequencer(pending_events.pop_front()));
        words_accepted++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_events.size() != 0) begin
          nv = 1'b1;
          nw = pending_events[0];
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        s_axis_tvalid <= nv;
        if (nv) begin
          s_axis_tdata <= {{(IN_TDATA_W-CHAN_W){1'b0}}, nw.chan};
          s_axis_tuser <= nw.func;
        end
      end
    end
  end

  // receiver ready pattern, with one long hold-off while the sender is busy
  always @(posedge clk) begin : status_sink
    logic rdy;
    rdy = 1'b1;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!long_stall_done && s_axis_tvalid && words_accepted >= STALL_AFTER) begin
        stall_left      = LONG_STALL;
        long_stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        if (sink_mode_left == 0) begin
          sink_mode      = $urandom_range(0, 2);
          sink_mode_left = $urandom_range(10, 80);
        end
        sink_mode_left--;
        case (sink_mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // monitor: each status word against the oldest expectation
  always @(posedge clk) begin : status_monitor
    status_word_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_status.size() == 0) begin
        report_error($sformatf("status word 0x%04h with none expected", m_axis_tdata));
      end else begin
        e = expected_status.pop_front();
        if (m_axis_tdata[3:0] !== e.fwd_mask)
          report_error($sformatf("forward_mask exp %h got %h", e.fwd_mask, m_axis_tdata[3:0]));
        if (m_axis_tdata[7:4] !== e.rev_mask)
          report_error($sformatf("reverse_mask exp %h got %h", e.rev_mask, m_axis_tdata[7:4]));
        if (m_axis_tdata[11:8] !== e.busy_mask)
          report_error($sformatf("busy_mask exp %h got %h", e.busy_mask, m_axis_tdata[11:8]));
        if (m_axis_tdata[12] !== e.led)
          report_error($sformatf("led exp %b got %b", e.led, m_axis_tdata[12]));
        if (m_axis_tdata[OUT_TDATA_W-1:13] !== '0)
          report_error($sformatf("padding bits set: 0x%04h", m_axis_tdata));
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int n;
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // enable still clear: triggers only toggle the led
    queue_event(FUNC_TRIGGER, 2'd0);
    queue_event(FUNC_TRIGGER, 2'd3);
    queue_event(FUNC_TICK, 2'd3);
    queue_event(FUNC_TICK, 2'd0);
    queue_event(FUNC_TRIGGER, 2'd1);
    wait_drained();

    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_OPEN_TICKS, 16'd0);
    write_reg(REG_HOLD_TICKS, 16'd2);
    write_reg(REG_CLOSE_TICKS, 16'd0);
    // start, retrigger while opening, restart the hold count, full sequence
    queue_event(FUNC_TRIGGER, 2'd0);
    queue_event(FUNC_TICK, 2'd0);
    queue_event(FUNC_TRIGGER, 2'd0);
    queue_event(FUNC_TRIGGER, 2'd1);
    queue_event(FUNC_TICK, 2'd2);
    queue_event(FUNC_TICK, 2'd1);
    queue_event(FUNC_TICK, 2'd3);
    queue_event(FUNC_TRIGGER, 2'd0);
    queue_event(FUNC_TRIGGER, 2'd3);
    repeat (8) queue_event(FUNC_TICK, 2'd0);
    wait_drained();

    // thresholds at maximum, then one lowered while a channel is opening
    write_reg(REG_OPEN_TICKS, 16'hFFFF);
    write_reg(REG_HOLD_TICKS, 16'hFFFF);
    write_reg(REG_CLOSE_TICKS, 16'hFFFF);
    queue_event(FUNC_TRIGGER, 2'd2);
    repeat (3) queue_event(FUNC_TICK, 2'd1);
    wait_drained();
    write_reg(REG_OPEN_TICKS, 16'd0);
    repeat (3) queue_event(FUNC_TICK, 2'd2);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      write_reg(REG_ENABLE, (p == 3 || $urandom_range(0, 9) == 0) ? 16'd0 : 16'd1);
      write_reg(REG_OPEN_TICKS, pick_ticks());
      write_reg(REG_HOLD_TICKS, pick_ticks());
      write_reg(REG_CLOSE_TICKS, pick_ticks());
      n = 0;
      while (n < PHASE_WORDS) begin
        if ($urandom_range(0, 4) == 0) begin
          queue_event(1'($urandom_range(0, 1)), CHAN_W'($urandom_range(0, 3)));
          n++;
        end else begin
          // trigger followed by a run of ticks, a stray trigger now and then
          queue_event(FUNC_TRIGGER, CHAN_W'($urandom_range(0, 3)));
          n++;
          k = $urandom_range(1, 30);
          repeat (k) begin
            if ($urandom_range(0, 9) == 0)
              queue_event(FUNC_TRIGGER, CHAN_W'($urandom_range(0, 3)));
            else
              queue_event(FUNC_TICK, CHAN_W'($urandom_range(0, 3)));
            n++;
          end
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (expected_status.size() != 0)
      report_error($sformatf("%0d status words never arrived", expected_status.size()));
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
